// ===== sv/blpq_pkg.sv =====
// ----------------------------------------------------------------------------
// blpq_pkg
// Shared types and constants for the byte limited packet queue: item and
// result payloads, controller states and the command bundle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package blpq_pkg;

    // storage geometry
    localparam int QUEUE_DEPTH = 1024;
    localparam int HANDLE_BITS = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // field widths
    localparam int FIELD_W  = 16;
    localparam int CAP_W    = 24;
    localparam int OVH_W    = 8;
    localparam int SLOT_W   = 10;
    localparam int BYTES_W  = 25;
    localparam int COUNT_W  = 10;
    localparam int COST_W   = FIELD_W + 1;
    localparam int SUM_W    = BYTES_W + 1;
    localparam int CMP_W    = ((COUNT_W > PTR_W) ? COUNT_W : PTR_W) + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OVERHEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLOTS    = 2'd2;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET = 24'd65536;
    localparam logic [OVH_W-1:0]  OVERHEAD_RESET = 8'd24;
    localparam logic [SLOT_W-1:0] SLOTS_RESET    = 10'd1023;

    // operation codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] packet_handle;
        logic [FIELD_W-1:0] packet_length;
    } item_t;

    typedef struct packed {
        logic               done_res;
        logic [FIELD_W-1:0] popped_handle;
        logic [FIELD_W-1:0] popped_length;
        logic [BYTES_W-1:0] bytes_in_use;
        logic [COUNT_W-1:0] entries_held;
    } result_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [FIELD_W-1:0]     length;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ_COST,
        ST_ENQ_COMMIT,
        ST_DEQ_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;   // latch item, enqueue cost
        logic deq_read;    // read head entry
        logic deq_cost;    // cost of the popped entry
        logic enq_commit;
        logic deq_commit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== sv/blpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// blpq_ctrl
// Controller: sequences one queue operation at a time and issues the
// per-step commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module blpq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               is_dequeue,
    output logic                    busy,
    output blpq_pkg::ctrl_cmd_t     cmd
);

    blpq_pkg::ctrl_state_t state_reg;
    blpq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            blpq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    if (is_dequeue == blpq_pkg::CMD_DEQUEUE)
                    begin
                        cmd.deq_read = 1'b1;
                        state_next   = blpq_pkg::ST_DEQ_COST;
                    end
                    else
                    begin
                        state_next = blpq_pkg::ST_ENQ_COMMIT;
                    end
                end
            end
            blpq_pkg::ST_DEQ_COST:
            begin
                cmd.deq_cost = 1'b1;
                state_next   = blpq_pkg::ST_DEQ_COMMIT;
            end
            blpq_pkg::ST_ENQ_COMMIT:
            begin
                cmd.enq_commit = 1'b1;
                state_next     = blpq_pkg::ST_IDLE;
            end
            blpq_pkg::ST_DEQ_COMMIT:
            begin
                cmd.deq_commit = 1'b1;
                state_next     = blpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = blpq_pkg::ST_IDLE;
            end
        endcase
    end

    // commit steps only follow an earlier step of the same operation
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_commit |-> $past(cmd.load_item) && !$past(cmd.deq_read))
        else $error("enqueue commit without an enqueue load");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq_commit |-> $past(cmd.deq_cost))
        else $error("dequeue commit without cost step");

endmodule

`default_nettype wire

// ===== sv/blpq_dpath.sv =====
// ----------------------------------------------------------------------------
// blpq_dpath
// Datapath: descriptor memory, head/tail pointers, entry and byte counters,
// configuration registers and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module blpq_dpath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire blpq_pkg::ctrl_cmd_t                cmd,
    input  wire blpq_pkg::item_t                    item,
    input  wire logic                               cfg_write,
    input  wire logic [blpq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [blpq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                    result_valid,
    output blpq_pkg::result_t                       result
);

    localparam int PtrW   = blpq_pkg::PTR_W;
    localparam int HandleW = blpq_pkg::HANDLE_BITS;
    localparam int FieldW = blpq_pkg::FIELD_W;
    localparam int CostW  = blpq_pkg::COST_W;
    localparam int SumW   = blpq_pkg::SUM_W;
    localparam int BytesW = blpq_pkg::BYTES_W;
    localparam int CountW = blpq_pkg::COUNT_W;
    localparam int CmpW   = blpq_pkg::CMP_W;

    // configuration
    logic [blpq_pkg::CAP_W-1:0]  capacity_reg;
    logic [blpq_pkg::OVH_W-1:0]  overhead_reg;
    logic [blpq_pkg::SLOT_W-1:0] slot_limit_reg;

    // queue state
    logic [PtrW-1:0]   head_reg;
    logic [PtrW-1:0]   tail_reg;
    logic [CountW-1:0] entry_count_reg;
    logic [BytesW-1:0] byte_total_reg;

    // working registers
    blpq_pkg::item_t   item_reg;
    logic [CostW-1:0]  cost_reg;
    blpq_pkg::entry_t  rd_entry_reg;
    logic              result_valid_reg;
    blpq_pkg::result_t result_reg;

    blpq_pkg::entry_t  mem [blpq_pkg::QUEUE_DEPTH];

    logic              slot_free;
    logic              bytes_ok;
    logic              enq_ok;
    logic [SumW-1:0]   enq_sum;
    logic [BytesW-1:0] deq_cost;
    logic [BytesW-1:0] deq_total;
    logic              not_empty;
    blpq_pkg::entry_t  wr_entry;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(blpq_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PtrW'(1);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= blpq_pkg::CAPACITY_RESET;
            overhead_reg   <= blpq_pkg::OVERHEAD_RESET;
            slot_limit_reg <= blpq_pkg::SLOTS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                blpq_pkg::CFG_IDX_CAPACITY: capacity_reg   <= cfg_data;
                blpq_pkg::CFG_IDX_OVERHEAD: overhead_reg   <= cfg_data[blpq_pkg::OVH_W-1:0];
                blpq_pkg::CFG_IDX_SLOTS:    slot_limit_reg <= cfg_data[blpq_pkg::SLOT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // admission check
    always_comb
    begin
        slot_free = (CmpW'(entry_count_reg) < CmpW'(slot_limit_reg))
                 && (CmpW'(entry_count_reg) < CmpW'(blpq_pkg::QUEUE_DEPTH));
        enq_sum   = SumW'(byte_total_reg) + SumW'(cost_reg);
        bytes_ok  = (byte_total_reg == '0) || (enq_sum < SumW'(capacity_reg));
        enq_ok    = slot_free && bytes_ok;
        not_empty = (entry_count_reg != '0);
        deq_cost  = BytesW'(cost_reg);
        // saturating release of the popped cost
        deq_total = (byte_total_reg > deq_cost) ? (byte_total_reg - deq_cost) : '0;
        wr_entry.handle = HandleW'(item_reg.packet_handle);
        wr_entry.length = item_reg.packet_length;
    end

    // descriptor memory
    always_ff @(posedge clk)
    begin
        if (cmd.enq_commit && enq_ok)
        begin
            mem[tail_reg] <= wr_entry;
        end
        if (cmd.deq_read)
        begin
            rd_entry_reg <= mem[head_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
            cost_reg <= CostW'(item.packet_length) + CostW'(overhead_reg);
        end
        else if (cmd.deq_cost)
        begin
            cost_reg <= CostW'(rd_entry_reg.length) + CostW'(overhead_reg);
        end

        if (cmd.enq_commit)
        begin
            result_reg.done_res      <= enq_ok;
            result_reg.popped_handle <= '0;
            result_reg.popped_length <= '0;
            result_reg.bytes_in_use  <= enq_ok ? BytesW'(enq_sum) : byte_total_reg;
            result_reg.entries_held  <= enq_ok ? entry_count_reg + CountW'(1)
                                               : entry_count_reg;
        end
        else if (cmd.deq_commit)
        begin
            result_reg.done_res      <= not_empty;
            result_reg.popped_handle <= not_empty ? FieldW'(rd_entry_reg.handle) : '0;
            result_reg.popped_length <= not_empty ? rd_entry_reg.length : '0;
            result_reg.bytes_in_use  <= not_empty ? deq_total : byte_total_reg;
            result_reg.entries_held  <= not_empty ? entry_count_reg - CountW'(1)
                                                  : entry_count_reg;
        end
    end

    // queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            entry_count_reg  <= '0;
            byte_total_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.enq_commit || cmd.deq_commit;
            if (cmd.enq_commit && enq_ok)
            begin
                tail_reg        <= ptr_inc(tail_reg);
                entry_count_reg <= entry_count_reg + CountW'(1);
                byte_total_reg  <= BytesW'(enq_sum);
            end
            else if (cmd.deq_commit && not_empty)
            begin
                head_reg        <= ptr_inc(head_reg);
                entry_count_reg <= entry_count_reg - CountW'(1);
                byte_total_reg  <= deq_total;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(cmd.enq_commit) || $past(cmd.deq_commit))
        else $error("result strobe without a commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_commit && enq_ok |=>
            entry_count_reg == $past(entry_count_reg) + CountW'(1))
        else $error("accepted enqueue did not add an entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq_commit && !not_empty |=>
            $stable(byte_total_reg) && $stable(head_reg) && !result.done_res)
        else $error("empty dequeue changed the queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result.entries_held == entry_count_reg
                          && result.bytes_in_use == byte_total_reg)
        else $error("reported usage differs from queue state");

endmodule

`default_nettype wire

// ===== sv/byte_limited_packet_queue_top.sv =====
// ----------------------------------------------------------------------------
// byte_limited_packet_queue_top
// FIFO of packet descriptors whose admission is bounded by accounted bytes
// (length plus per-frame overhead) and by a slot limit; excess is tail-dropped.
//
//   channel   signals                              direction  transfer when
//   item      start, busy, item                    in         start && !busy
//   result    result_valid, result                 out        result_valid
//   config    cfg_valid, cfg_ready, cfg_index,     in         cfg_valid && cfg_ready
//             cfg_data
//
// an enqueue goes from accept through a commit step to its result; the
// dequeue path adds a cost step and is set by the registered read of the
// descriptor memory followed by the cost adder ahead of the saturating subtract.
// busy is high while an operation is in flight; the next item can be
// accepted in the cycle its predecessor's result is shown.
// reset clears pointers, counters and the strobe; memory contents are kept.
// the result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_limited_packet_queue_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire blpq_pkg::item_t                    item,
    output logic                                    result_valid,
    output blpq_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [blpq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [blpq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    blpq_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    blpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .is_dequeue (item.command),
        .busy       (busy),
        .cmd        (cmd)
    );

    blpq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
